[sv/sorted_priority_queue_defines.svh]
// Assertion macros for the sorted priority queue.
// Both macros sample on i_clk and stay quiet while i_rst_n is low.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue: same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue: next-cycle check failed");

`endif

[sv/spq_pkg.sv]
`default_nettype none
package spq_pkg;

    // Default sizing
    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_ID_BITS       = 8;
    localparam int DEF_PRIORITY_BITS = 8;

    // Fixed result field widths
    localparam int STATUS_BITS = 2;
    localparam int OCC_BITS    = 5;

    // Operation codes
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // Status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic enq;   // insert the new word into the chain
        logic deq;   // shift the chain toward cell 0
    } t_cell_ctrl;

endpackage
`default_nettype wire

[sv/spq_ifs.sv]
`default_nettype none
// Request channel: one operation word per handshake.
interface spq_req_if #(
    parameter int ID_BITS       = spq_pkg::DEF_ID_BITS,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
);
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [ID_BITS-1:0]       entry_id;
    logic [PRIORITY_BITS-1:0] entry_priority;

    modport source (output valid, mode, entry_id, entry_priority, input ready);
    modport sink   (input valid, mode, entry_id, entry_priority, output ready);
endinterface

// Response channel: one result word per request.
interface spq_rsp_if #(
    parameter int ID_BITS       = spq_pkg::DEF_ID_BITS,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
);
    logic                                valid;
    logic                                ready;
    logic                                served_valid;
    logic [ID_BITS-1:0]                  served_id;
    logic [PRIORITY_BITS-1:0]            served_priority;
    logic [spq_pkg::STATUS_BITS-1:0]     status;
    logic [spq_pkg::OCC_BITS-1:0]        occupancy;

    modport source (output valid, served_valid, served_id, served_priority, status,
                    occupancy, input ready);
    modport sink   (input valid, served_valid, served_id, served_priority, status,
                    occupancy, output ready);
endinterface
`default_nettype wire

[sv/sorted_priority_queue.sv]
// The response word is registered and appears in the cycle after its request word is accepted.
// Throughput: one request per cycle while the response side takes words;
// a full chain shift or insert finishes in the accepting cycle.
// Reset (synchronous, active low) empties the queue and drops a pending
// response; slot contents are not cleared and are never read while empty.
`default_nettype none
`include "sorted_priority_queue_defines.svh"
module sorted_priority_queue #(
    parameter int QUEUE_DEPTH   = spq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_BITS       = spq_pkg::DEF_ID_BITS,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_BITS = spq_pkg::OCC_BITS;
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);

    logic [CNT_BITS-1:0]       r_count;
    logic [CNT_BITS-1:0]       n_count;
    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    spq_pkg::t_cell_ctrl       w_ctrl;
    logic [ID_BITS-1:0]        w_id   [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0]  w_prio [QUEUE_DEPTH];
    logic                      w_keep [QUEUE_DEPTH];
    logic [CNT_BITS+OCC_BITS-1:0] w_occ_wide;

    logic                            r_rsp_valid;
    logic                            r_served_valid;
    logic [ID_BITS-1:0]              r_served_id;
    logic [PRIORITY_BITS-1:0]        r_served_prio;
    logic [spq_pkg::STATUS_BITS-1:0] r_status;
    logic [OCC_BITS-1:0]             r_occ;

    // Accept a new word whenever the response register is free or draining
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == FULL_COUNT);
    assign w_empty     = (r_count == '0);

    // Decode the operation into chain control
    always_comb begin
        w_ctrl.enq = w_accept && (i_req.mode == spq_pkg::MODE_ENQ) && !w_full;
        w_ctrl.deq = w_accept && (i_req.mode == spq_pkg::MODE_DEQ) && !w_empty;
        n_count    = r_count;
        if (w_ctrl.enq) begin
            n_count = r_count + 1'b1;
        end else if (w_ctrl.deq) begin
            n_count = r_count - 1'b1;
        end
    end

    // Build the chain; cell 0 is the serving end
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        localparam logic [CNT_BITS-1:0] K_IDX = CNT_BITS'(k);
        localparam int PREV = (k == 0) ? 0 : k - 1;
        localparam int NEXT = (k == QUEUE_DEPTH - 1) ? k : k + 1;

        spq_cell #(
            .ID_BITS       (ID_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_occ       (K_IDX < r_count),
            .i_new_id    (i_req.entry_id),
            .i_new_prio  (i_req.entry_priority),
            .i_prev_keep ((k == 0) ? 1'b1 : w_keep[PREV]),
            .i_prev_id   (w_id[PREV]),
            .i_prev_prio (w_prio[PREV]),
            .i_next_id   (w_id[NEXT]),
            .i_next_prio (w_prio[NEXT]),
            .o_keep      (w_keep[k]),
            .o_id        (w_id[k]),
            .o_prio      (w_prio[k])
        );
    end

    // Occupancy wraps within its field when the depth exceeds it
    assign w_occ_wide = {{OCC_BITS{1'b0}}, n_count};

    // Advance the entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Hold the response word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_accept) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    // Capture the response payload on accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_served_valid <= w_ctrl.deq;
            r_served_id    <= w_ctrl.deq ? w_id[0] : '0;
            r_served_prio  <= w_ctrl.deq ? w_prio[0] : '0;
            r_occ          <= w_occ_wide[OCC_BITS-1:0];
            if (i_req.mode == spq_pkg::MODE_ENQ) begin
                r_status <= w_full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_OK;
            end else begin
                r_status <= w_empty ? spq_pkg::STATUS_EMPTY : spq_pkg::STATUS_OK;
            end
        end
    end

    assign o_rsp.valid           = r_rsp_valid;
    assign o_rsp.served_valid    = r_served_valid;
    assign o_rsp.served_id       = r_served_id;
    assign o_rsp.served_priority = r_served_prio;
    assign o_rsp.status          = r_status;
    assign o_rsp.occupancy       = r_occ;

    // Checks
    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= FULL_COUNT)
    `SPQ_ASSERT_NEXT(a_deq_serves, w_ctrl.deq, r_rsp_valid && r_served_valid)
    `SPQ_ASSERT_NEXT(a_enq_grows, w_ctrl.enq, r_count == $past(r_count) + 1'b1)
    `SPQ_ASSERT_NOW(a_head_sorted, r_count >= CNT_BITS'(2) && QUEUE_DEPTH > 1,
                    w_prio[0] <= w_prio[1])

endmodule
`default_nettype wire

[sv/spq_cell.sv]
`default_nettype none
// One slot of the sorted chain. Cell 0 holds the next entry to be served;
// priorities do not decrease toward the far end, oldest first among equals.
module spq_cell #(
    parameter int ID_BITS       = spq_pkg::DEF_ID_BITS,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
    input  wire logic                     i_clk,
    input  wire spq_pkg::t_cell_ctrl      i_ctrl,
    input  wire logic                     i_occ,
    input  wire logic [ID_BITS-1:0]       i_new_id,
    input  wire logic [PRIORITY_BITS-1:0] i_new_prio,
    input  wire logic                     i_prev_keep,
    input  wire logic [ID_BITS-1:0]       i_prev_id,
    input  wire logic [PRIORITY_BITS-1:0] i_prev_prio,
    input  wire logic [ID_BITS-1:0]       i_next_id,
    input  wire logic [PRIORITY_BITS-1:0] i_next_prio,
    output logic                          o_keep,
    output logic [ID_BITS-1:0]            o_id,
    output logic [PRIORITY_BITS-1:0]      o_prio
);

    logic [ID_BITS-1:0]       r_id;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic [ID_BITS-1:0]       n_id;
    logic [PRIORITY_BITS-1:0] n_prio;

    // Hold the slot when it is served before the new word
    assign o_keep = i_occ && (r_prio <= i_new_prio);

    // Pick the next slot contents: hold, take the new word, take the
    // neighbor below on insert, or the neighbor above on removal
    always_comb begin
        n_id   = r_id;
        n_prio = r_prio;
        if (i_ctrl.enq && !o_keep) begin
            if (i_prev_keep) begin
                n_id   = i_new_id;
                n_prio = i_new_prio;
            end else begin
                n_id   = i_prev_id;
                n_prio = i_prev_prio;
            end
        end else if (i_ctrl.deq) begin
            n_id   = i_next_id;
            n_prio = i_next_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
    end

    assign o_id   = r_id;
    assign o_prio = r_prio;

endmodule
`default_nettype wire

[tb/sorted_priority_queue_test.sv]
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue_test;

    localparam int DEPTH       = spq_pkg::DEF_QUEUE_DEPTH;
    localparam int ID_W        = spq_pkg::DEF_ID_BITS;
    localparam int PRIO_W      = spq_pkg::DEF_PRIORITY_BITS;
    localparam int ST_W        = spq_pkg::STATUS_BITS;
    localparam int OCC_W       = spq_pkg::OCC_BITS;
    localparam int RANDOM_WORDS = 476;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 10;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic              mode;
        logic [ID_W-1:0]   entry_id;
        logic [PRIO_W-1:0] entry_priority;
    } t_req_word;

    typedef struct {
        logic              served_valid;
        logic [ID_W-1:0]   served_id;
        logic [PRIO_W-1:0] served_priority;
        logic [ST_W-1:0]   status;
        logic [OCC_W-1:0]  occupancy;
    } t_rsp_word;

    logic i_clk;
    logic i_rst_n;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    sorted_priority_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Words still to be sent, and responses owed by the block
    t_req_word req_words[$];
    t_rsp_word rsp_due[$];
    int        total_words;
    int        sent_count;
    int        error_count;
    int        cycle_count;

    // Shadow of the sorted chain: slot 0 is the head, the tail is served first
    logic [ID_W-1:0]   chain_id[DEPTH];
    logic [PRIO_W-1:0] chain_prio[DEPTH];
    int                chain_count;

    // Insert or serve one request word and return the response it owes
    function automatic t_rsp_word chain_update(t_req_word w);
        t_rsp_word r;
        int        pos;
        r = '{served_valid: 1'b0, served_id: '0, served_priority: '0,
              status: spq_pkg::STATUS_OK, occupancy: '0};
        if (w.mode == spq_pkg::MODE_ENQ) begin
            if (chain_count >= DEPTH) begin
                r.status = spq_pkg::STATUS_FULL;
            end else begin
                pos = 0;
                while (pos < chain_count && chain_prio[pos] > w.entry_priority)
                    pos++;
                for (int k = chain_count; k > pos; k--) begin
                    chain_id[k]   = chain_id[k-1];
                    chain_prio[k] = chain_prio[k-1];
                end
                chain_id[pos]   = w.entry_id;
                chain_prio[pos] = w.entry_priority;
                chain_count++;
            end
        end else begin
            if (chain_count == 0) begin
                r.status = spq_pkg::STATUS_EMPTY;
            end else begin
                chain_count--;
                r.served_valid    = 1'b1;
                r.served_id       = chain_id[chain_count];
                r.served_priority = chain_prio[chain_count];
            end
        end
        r.occupancy = chain_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic add_word(logic mode, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
        t_req_word w;
        w.mode           = mode;
        w.entry_id       = id;
        w.entry_priority = prio;
        req_words.push_back(w);
    endtask

    // Idle rates by phase: sender light and receiver heavy, then swapped, then none
    function automatic int send_idle_pct();
        if (sent_count < total_words / 3)
            return 32;
        else if (sent_count < (2 * total_words) / 3)
            return 87;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (sent_count < total_words / 3)
            return 87;
        else if (sent_count < (2 * total_words) / 3)
            return 32;
        return 0;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Reset and known input values from time zero
    initial begin
        i_rst_n               = 1'b0;
        req_if.valid          = 1'b0;
        req_if.mode           = spq_pkg::MODE_ENQ;
        req_if.entry_id       = '0;
        req_if.entry_priority = '0;
        rsp_if.ready          = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Build the stimulus
    initial begin
        int bias;
        int run_len;
        int enq_pct;
        logic [PRIO_W-1:0] prio;
        chain_count = 0;
        sent_count  = 0;
        error_count = 0;

        // Dequeue on empty with nonzero ignored fields
        add_word(spq_pkg::MODE_DEQ, 8'hFF, 8'hFF);
        // Field extremes, priority ties, then fill past full
        add_word(spq_pkg::MODE_ENQ, 8'h00, 8'hFF);
        add_word(spq_pkg::MODE_ENQ, 8'hFF, 8'h00);
        add_word(spq_pkg::MODE_ENQ, 8'hAA, 8'h80);
        add_word(spq_pkg::MODE_ENQ, 8'h55, 8'h80);
        add_word(spq_pkg::MODE_ENQ, 8'h0F, 8'h00);
        add_word(spq_pkg::MODE_ENQ, 8'hF0, 8'hFF);
        for (int k = 0; k < 11; k++)
            add_word(spq_pkg::MODE_ENQ, 8'(16 + k), 8'(100 + (k % 3)));
        // Drain part of the chain; ignored fields vary
        for (int k = 0; k < 6; k++)
            add_word(spq_pkg::MODE_DEQ, 8'(k * 51), 8'(255 - k * 37));

        // Random runs biased toward filling, draining or churning
        while (req_words.size() < 24 + RANDOM_WORDS) begin
            bias    = $urandom_range(0, 2);
            run_len = $urandom_range(10, 40);
            enq_pct = (bias == 0) ? 85 : (bias == 1) ? 15 : 50;
            for (int k = 0; k < run_len; k++) begin
                if ($urandom_range(0, 1) == 0)
                    prio = PRIO_W'($urandom_range(0, 3));
                else
                    prio = PRIO_W'($urandom);
                if ($urandom_range(0, 99) < enq_pct)
                    add_word(spq_pkg::MODE_ENQ, ID_W'($urandom), prio);
                else
                    add_word(spq_pkg::MODE_DEQ, ID_W'($urandom), prio);
            end
        end
        total_words = req_words.size();
    end

    // Driver: hold the word until accepted, then load the next or idle
    always @(posedge i_clk) begin
        t_req_word w;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                w.mode           = req_if.mode;
                w.entry_id       = req_if.entry_id;
                w.entry_priority = req_if.entry_priority;
                rsp_due.push_back(chain_update(w));
                sent_count++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (req_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                    w = req_words.pop_front();
                    req_if.valid          <= 1'b1;
                    req_if.mode           <= w.mode;
                    req_if.entry_id       <= w.entry_id;
                    req_if.entry_priority <= w.entry_priority;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, check each accepted word against the oldest owed
    always @(posedge i_clk) begin
        t_rsp_word want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
            if (rsp_if.valid && rsp_if.ready) begin
                if (rsp_due.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unowed word: valid=%0d id=%0h prio=%0h st=%0d occ=%0d",
                                 rsp_if.served_valid, rsp_if.served_id,
                                 rsp_if.served_priority, rsp_if.status, rsp_if.occupancy);
                end else begin
                    want = rsp_due.pop_front();
                    if (rsp_if.served_valid !== want.served_valid ||
                        rsp_if.served_id !== want.served_id ||
                        rsp_if.served_priority !== want.served_priority ||
                        rsp_if.status !== want.status ||
                        rsp_if.occupancy !== want.occupancy) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display("mismatch: exp valid=%0d id=%0h prio=%0h st=%0d occ=%0d",
                                     want.served_valid, want.served_id,
                                     want.served_priority, want.status, want.occupancy);
                            $display("          got valid=%0d id=%0h prio=%0h st=%0d occ=%0d",
                                     rsp_if.served_valid, rsp_if.served_id,
                                     rsp_if.served_priority, rsp_if.status,
                                     rsp_if.occupancy);
                        end
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL sorted_priority_queue");
            $finish;
        end
    end

    // Wait for all words sent and answered, let stray words show, then judge
    initial begin
        cycle_count = 0;
        wait (i_rst_n === 1'b1);
        wait (total_words > 0 && sent_count == total_words && rsp_due.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (rsp_due.size() != 0)
            error_count++;
        if (error_count == 0) begin
            $display("PASS sorted_priority_queue");
        end else begin
            $display("FAIL sorted_priority_queue");
        end
        $finish;
    end

endmodule
`default_nettype wire
